// File: rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the pulse charge controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int DATA_W  = 16;
  localparam int TIMER_W = 17;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 3;

  // Phase codes
  localparam logic [1:0] PH_OFF   = 2'd0;
  localparam logic [1:0] PH_WORK  = 2'd1;
  localparam logic [1:0] PH_PAUSE = 2'd2;

  // Item mode codes; the unused code is handled as a poll
  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_WORK_MS          = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAUSE_MS         = 3'd1;
  localparam logic [IDX_W-1:0] REG_END_VOLTAGE      = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_CURRENT      = 3'd3;
  localparam logic [IDX_W-1:0] REG_START_CURRENT    = 3'd4;
  localparam logic [IDX_W-1:0] REG_COMPLETE_CURRENT = 3'd5;

  // Register reset values
  localparam logic [DATA_W-1:0] RST_WORK_MS          = 16'd5000;
  localparam logic [DATA_W-1:0] RST_PAUSE_MS         = 16'd5000;
  localparam logic [DATA_W-1:0] RST_END_VOLTAGE      = 16'd4200;
  localparam logic [DATA_W-1:0] RST_MAX_CURRENT      = 16'd5000;
  localparam logic [DATA_W-1:0] RST_START_CURRENT    = 16'd1000;
  localparam logic [DATA_W-1:0] RST_COMPLETE_CURRENT = 16'd20;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [CNT_W-1:0]   DIV_STEPS = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHECK,
    ST_DIV_END,
    ST_DIV_CUR,
    ST_RETUNE,
    ST_CLOSE,
    ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic check;
    logic div_start;
    logic div_sel_cur;
    logic retune;
    logic close;
    logic load_out;
  } pcc_cmd_t;

  typedef struct packed {
    logic need_retune;
    logic need_div;
    logic div_busy;
    logic out_free;
  } pcc_status_t;

endpackage

// File: rtl/core/pcc_div.sv
// ----------------------------------------------------------------------------
// pcc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pcc_pkg::DATA_W-1:0] dividend,
  input  logic [pcc_pkg::DATA_W-1:0] divisor,
  output logic                       busy,
  output logic [pcc_pkg::DATA_W-1:0] quotient
);

  logic [pcc_pkg::DATA_W-1:0] rem;
  logic [pcc_pkg::DATA_W-1:0] quo;
  logic [pcc_pkg::DATA_W-1:0] dsr;
  logic [pcc_pkg::CNT_W-1:0]  cnt;
  logic [pcc_pkg::DATA_W:0]   shifted;
  logic [pcc_pkg::DATA_W+1:0] trial;
  logic                       borrow;

  assign shifted = {rem, quo[pcc_pkg::DATA_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};
  assign borrow  = trial[pcc_pkg::DATA_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= pcc_pkg::DIV_STEPS;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (cnt != '0) begin
      // keep the partial remainder when the trial subtract borrows
      rem <= borrow ? shifted[pcc_pkg::DATA_W-1:0] : trial[pcc_pkg::DATA_W-1:0];
      quo <= {quo[pcc_pkg::DATA_W-2:0], ~borrow};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

// File: rtl/core/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl
// Sequencer for one item: evaluate, divide twice and retune if due, report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  pcc_pkg::pcc_status_t  st,
  output pcc_pkg::pcc_cmd_t     cmd,
  output logic                  idle
);

  pcc_pkg::ctrl_state_t state;
  pcc_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcc_pkg::ST_IDLE: begin
        if (item_valid) state_next = pcc_pkg::ST_EVAL;
      end
      pcc_pkg::ST_EVAL: begin
        state_next = pcc_pkg::ST_CHECK;
      end
      pcc_pkg::ST_CHECK: begin
        if (st.need_div) begin
          state_next = pcc_pkg::ST_DIV_END;
        end else if (st.need_retune) begin
          state_next = pcc_pkg::ST_RETUNE;
        end else begin
          state_next = pcc_pkg::ST_HOLD;
        end
      end
      pcc_pkg::ST_DIV_END: begin
        if (!st.div_busy) state_next = pcc_pkg::ST_DIV_CUR;
      end
      pcc_pkg::ST_DIV_CUR: begin
        if (!st.div_busy) state_next = pcc_pkg::ST_RETUNE;
      end
      pcc_pkg::ST_RETUNE: begin
        state_next = pcc_pkg::ST_CLOSE;
      end
      pcc_pkg::ST_CLOSE: begin
        state_next = pcc_pkg::ST_HOLD;
      end
      pcc_pkg::ST_HOLD: begin
        if (st.out_free) state_next = pcc_pkg::ST_IDLE;
      end
      default: begin
        state_next = pcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state)
      pcc_pkg::ST_IDLE: begin
        idle        = 1'b1;
        cmd.capture = item_valid;
      end
      pcc_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      pcc_pkg::ST_CHECK: begin
        cmd.check     = 1'b1;
        cmd.div_start = st.need_div;
      end
      pcc_pkg::ST_DIV_END: begin
        // chain the second division straight off the first quotient
        cmd.div_start   = !st.div_busy;
        cmd.div_sel_cur = 1'b1;
      end
      pcc_pkg::ST_DIV_CUR: begin
        cmd.div_sel_cur = 1'b1;
      end
      pcc_pkg::ST_RETUNE: begin
        cmd.retune = 1'b1;
      end
      pcc_pkg::ST_CLOSE: begin
        cmd.close = 1'b1;
      end
      pcc_pkg::ST_HOLD: begin
        cmd.load_out = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/pcc_datapath.sv
// ----------------------------------------------------------------------------
// pcc_datapath
// Configuration, phase timer, setpoint retune and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  pcc_pkg::pcc_cmd_t           cmd,
  output pcc_pkg::pcc_status_t        st,
  input  logic                        cfg_we,
  input  logic [pcc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pcc_pkg::DATA_W-1:0]  cfg_data,
  input  logic [1:0]                  mode,
  input  logic [pcc_pkg::DATA_W-1:0]  elapsed_ms,
  input  logic [pcc_pkg::DATA_W-1:0]  battery_mv,
  input  logic                        result_stall,
  output logic                        result_valid,
  output logic [1:0]                  phase,
  output logic [pcc_pkg::DATA_W-1:0]  current_setpoint,
  output logic                        setpoint_changed,
  output logic                        status
);

  localparam int W = pcc_pkg::DATA_W;
  localparam int T = pcc_pkg::TIMER_W;

  logic [W-1:0] work_ms, pause_ms, end_voltage, max_current, start_current, complete_current;

  logic [1:0]   item_mode;
  logic [W-1:0] item_elapsed;
  logic [W-1:0] item_mv;

  logic [1:0]   phase_state;
  logic [T-1:0] phase_timer;
  logic [W-1:0] present_current;
  logic         changed;
  logic         done;
  logic         err_zero;
  logic         err_pos;
  logic [W-1:0] mag;

  logic         is_poll;
  logic [T:0]   timer_sum;
  logic [T-1:0] timer_adv;
  logic         work_due;
  logic         pause_due;
  logic [W-1:0] start_clamped;
  logic [W-1:0] div_dividend;
  logic [W-1:0] div_divisor;
  logic         div_busy;
  logic [W-1:0] quotient;
  logic [W-1:0] inc;
  logic [W:0]   cur_adj;
  logic [W-1:0] cur_new;
  logic         out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_ms          <= pcc_pkg::RST_WORK_MS;
      pause_ms         <= pcc_pkg::RST_PAUSE_MS;
      end_voltage      <= pcc_pkg::RST_END_VOLTAGE;
      max_current      <= pcc_pkg::RST_MAX_CURRENT;
      start_current    <= pcc_pkg::RST_START_CURRENT;
      complete_current <= pcc_pkg::RST_COMPLETE_CURRENT;
    end else if (cfg_we) begin
      case (cfg_index)
        pcc_pkg::REG_WORK_MS:          work_ms          <= cfg_data;
        pcc_pkg::REG_PAUSE_MS:         pause_ms         <= cfg_data;
        pcc_pkg::REG_END_VOLTAGE:      end_voltage      <= cfg_data;
        pcc_pkg::REG_MAX_CURRENT:      max_current      <= cfg_data;
        pcc_pkg::REG_START_CURRENT:    start_current    <= cfg_data;
        pcc_pkg::REG_COMPLETE_CURRENT: complete_current <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode    <= mode;
      item_elapsed <= elapsed_ms;
      item_mv      <= battery_mv;
    end
  end

  assign is_poll   = (item_mode != pcc_pkg::MODE_START) && (item_mode != pcc_pkg::MODE_STOP);
  assign timer_sum = {1'b0, phase_timer} + {{(T + 1 - W){1'b0}}, item_elapsed};
  assign timer_adv = timer_sum[T] ? pcc_pkg::TIMER_MAX : timer_sum[T-1:0];
  assign start_clamped = (start_current > max_current) ? max_current : start_current;

  assign work_due  = is_poll && (phase_state == pcc_pkg::PH_WORK)
                     && (phase_timer >= {1'b0, work_ms});
  assign pause_due = is_poll && (phase_state == pcc_pkg::PH_PAUSE)
                     && (phase_timer >= {1'b0, pause_ms});

  // First division: end / |error|; second: current / max(quotient, 1)
  assign div_dividend = cmd.div_sel_cur ? present_current : end_voltage;
  assign div_divisor  = cmd.div_sel_cur ? ((quotient == '0) ? W'(1) : quotient) : mag;

  pcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign inc     = err_zero ? '0 : quotient;
  assign cur_adj = err_pos ? ({1'b0, present_current} - {1'b0, inc})
                           : ({1'b0, present_current} + {1'b0, inc});
  assign cur_new = (cur_adj > {1'b0, max_current}) ? max_current : cur_adj[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_state     <= pcc_pkg::PH_OFF;
      phase_timer     <= '0;
      present_current <= '0;
    end else if (cmd.eval) begin
      if (item_mode == pcc_pkg::MODE_START) begin
        phase_state     <= pcc_pkg::PH_WORK;
        phase_timer     <= '0;
        present_current <= start_clamped;
      end else if (item_mode == pcc_pkg::MODE_STOP) begin
        phase_state <= pcc_pkg::PH_OFF;
        phase_timer <= '0;
      end else if (phase_state != pcc_pkg::PH_OFF) begin
        phase_timer <= timer_adv;
      end
    end else if (cmd.check) begin
      if (pause_due) begin
        phase_state <= pcc_pkg::PH_WORK;
        phase_timer <= phase_timer - {1'b0, pause_ms};
      end
    end else if (cmd.retune) begin
      present_current <= cur_new;
    end else if (cmd.close) begin
      if (present_current <= complete_current) begin
        phase_state <= pcc_pkg::PH_OFF;
        phase_timer <= '0;
      end else begin
        phase_state <= pcc_pkg::PH_PAUSE;
        phase_timer <= phase_timer - {1'b0, work_ms};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      changed  <= 1'b0;
      done     <= 1'b0;
      err_zero <= (item_mv == end_voltage);
      err_pos  <= (item_mv > end_voltage);
      mag      <= (item_mv > end_voltage) ? (item_mv - end_voltage) : (end_voltage - item_mv);
    end else if (cmd.retune) begin
      changed <= (cur_new != present_current);
    end else if (cmd.close) begin
      done <= (present_current <= complete_current);
    end
  end

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      phase            <= phase_state;
      current_setpoint <= present_current;
      setpoint_changed <= changed;
      status           <= done;
    end
  end

  assign st.need_retune = work_due;
  assign st.need_div    = work_due && !err_zero;
  assign st.div_busy    = div_busy;
  assign st.out_free    = out_free;

endmodule

// File: rtl/core/pulse_charge_controller_top.sv
// ----------------------------------------------------------------------------
// pulse_charge_controller_top
// Pulse charger: working/pause phase timer, setpoint retune at work phase end.
// An item is evaluated and checked; at work phase end the setpoint is retuned,
// directly if the error is zero, else after two runs of the shared divider.
// One item at a time: the next item is taken the cycle after the result is
// registered; the output register frees the input.
// Synchronous reset loads register defaults and clears phase, timer, setpoint.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_charge_controller_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pcc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pcc_pkg::DATA_W-1:0]  cfg_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  mode,
  input  logic [pcc_pkg::DATA_W-1:0]  elapsed_ms,
  input  logic [pcc_pkg::DATA_W-1:0]  battery_mv,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [1:0]                  phase,
  output logic [pcc_pkg::DATA_W-1:0]  current_setpoint,
  output logic                        setpoint_changed,
  output logic                        status
);

  pcc_pkg::pcc_cmd_t    cmd;
  pcc_pkg::pcc_status_t st;
  logic                 idle;

  pcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .st         (st),
    .cmd        (cmd),
    .idle       (idle)
  );

  pcc_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mode             (mode),
    .elapsed_ms       (elapsed_ms),
    .battery_mv       (battery_mv),
    .result_stall     (result_stall),
    .result_valid     (result_valid),
    .phase            (phase),
    .current_setpoint (current_setpoint),
    .setpoint_changed (setpoint_changed),
    .status           (status)
  );

  assign item_stall = !idle;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("accepted item did not make the block busy");

  a_done_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> phase == pcc_pkg::PH_OFF)
    else $error("completion reported outside the off phase");

  a_retune_not_work: assert property (@(posedge clk) disable iff (rst)
    result_valid && setpoint_changed |-> phase != pcc_pkg::PH_WORK)
    else $error("setpoint change reported while still working");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result_valid)
    else $error("result load did not raise valid");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    st.div_busy |-> item_stall)
    else $error("divider running while input is open");

endmodule
